>>> rtl/core/tlv_pkg.sv
// Shared types and constants of the TLV element parser.
package tlv_pkg;

  // Number of big-endian length bytes after the type terminator (1 or 2)
  localparam int unsigned LENGTH_BYTES = 2;

  localparam int unsigned LenW = 16;
  localparam int unsigned NumW = 64;

  // Parser phase, one-hot
  typedef enum logic [2:0] {
    PH_TYPE   = 3'b001,
    PH_LENGTH = 3'b010,
    PH_VALUE  = 3'b100
  } phase_e;

  // Role of a byte inside an element
  typedef enum logic [1:0] {
    KIND_TYPE_CHAR = 2'd0,
    KIND_TYPE_TERM = 2'd1,
    KIND_LENGTH    = 2'd2,
    KIND_VALUE     = 2'd3
  } byte_kind_e;

  // One result item
  typedef struct packed {
    byte_kind_e        byte_kind;
    logic              element_done;
    logic [LenW-1:0]   element_length;
    logic [NumW-1:0]   numeral_value;
    logic              numeral_ok;
    logic              buffer_error;
  } tlv_result_t;

endpackage

>>> rtl/core/tlv_parse_core.sv
// Per-byte TLV state update and result generation.
module tlv_parse_core import tlv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_in_buffer_i,
  output tlv_result_t result_o
);

  phase_e            phase_q, phase_d;
  logic [1:0]        seen_q, seen_d;
  logic [LenW-1:0]   len_acc_q, len_acc_d;
  logic [LenW-1:0]   remain_q, remain_d;
  logic [NumW-1:0]   num_acc_q, num_acc_d;
  tlv_result_t       res;

  // Next state and result for the byte being transferred
  always_comb begin
    phase_d   = phase_q;
    seen_d    = seen_q;
    len_acc_d = len_acc_q;
    remain_d  = remain_q;
    num_acc_d = num_acc_q;
    res       = '0;

    case (phase_q)
      PH_LENGTH: begin
        res.byte_kind = KIND_LENGTH;
        len_acc_d = {len_acc_q[LenW-9:0], data_byte_i};
        seen_d    = 2'(seen_q + 2'd1);
        if (seen_d >= 2'(LENGTH_BYTES)) begin
          if (len_acc_d == '0) begin
            // zero length ends the element on its last length byte
            res.element_done = 1'b1;
            phase_d   = PH_TYPE;
            seen_d    = '0;
            len_acc_d = '0;
            remain_d  = '0;
            num_acc_d = '0;
          end else begin
            remain_d  = len_acc_d;
            num_acc_d = '0;
            phase_d   = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        res.byte_kind = KIND_VALUE;
        num_acc_d = {num_acc_q[NumW-9:0], data_byte_i};
        remain_d  = remain_q - 16'd1;
        if (remain_d == '0) begin
          res.element_done   = 1'b1;
          res.element_length = len_acc_q;
          res.numeral_value  = num_acc_d;
          res.numeral_ok     = (len_acc_q == 16'd1) || (len_acc_q == 16'd2) ||
                               (len_acc_q == 16'd4) || (len_acc_q == 16'd8);
          phase_d   = PH_TYPE;
          seen_d    = '0;
          len_acc_d = '0;
          remain_d  = '0;
          num_acc_d = '0;
        end
      end
      default: begin
        // type field; an unused phase code behaves the same
        if (data_byte_i == 8'd0) begin
          res.byte_kind = KIND_TYPE_TERM;
          phase_d   = PH_LENGTH;
          seen_d    = '0;
          len_acc_d = '0;
        end else begin
          res.byte_kind = KIND_TYPE_CHAR;
          phase_d   = PH_TYPE;
        end
      end
    endcase

    // buffer ended inside an element: flag and restart
    if (last_in_buffer_i && !res.element_done) begin
      res.buffer_error = 1'b1;
      phase_d   = PH_TYPE;
      seen_d    = '0;
      len_acc_d = '0;
      remain_d  = '0;
      num_acc_d = '0;
    end
  end

  // Parser state registers, updated on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_TYPE;
      seen_q    <= '0;
      len_acc_q <= '0;
      remain_q  <= '0;
      num_acc_q <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      seen_q    <= seen_d;
      len_acc_q <= len_acc_d;
      remain_q  <= remain_d;
      num_acc_q <= num_acc_d;
    end
  end

  assign result_o = res;

endmodule

>>> rtl/core/tlv_out_buf.sv
// Result register with a skid stage between the parser and the output.
module tlv_out_buf import tlv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  tlv_result_t result_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output tlv_result_t result_o
);

  logic        out_v_q, out_v_d;
  logic        skid_v_q, skid_v_d;
  tlv_result_t out_q, skid_q;
  logic        accept, take_out, out_free;

  assign in_stall_o = skid_v_q;
  assign accept     = in_valid_i && !skid_v_q;
  assign take_out   = out_v_q && !out_stall_i;
  assign out_free   = !out_v_q || take_out;

  // Occupancy of the two stages
  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    if (out_free) begin
      out_v_d  = skid_v_q || accept;
      skid_v_d = 1'b0;
    end else if (accept) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  // Payload: skid drains first, otherwise a new result lands where there is room
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= result_i;
      end
    end else if (accept) begin
      skid_q <= result_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign result_o    = out_q;

endmodule

>>> rtl/core/tlv_element_parser.sv
// Top level: streaming TLV element parser, one byte per transfer.
// Each result is registered in the output stage, or in the skid stage while the output is stalled.
// Throughput: one byte per cycle while in_stall_o is low; the per-byte state update is a single pass.
// A skid stage keeps input flowing for one extra item while a result waits.
// Reset (rst_ni low, asynchronous): parser returns to the type field,
// all accumulators clear and both output stages empty.
module tlv_element_parser import tlv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_in_buffer_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  byte_kind_o,
  output logic        element_done_o,
  output logic [15:0] element_length_o,
  output logic [63:0] numeral_value_o,
  output logic        numeral_ok_o,
  output logic        buffer_error_o
);

  tlv_result_t core_res, out_res;
  logic        accept;

  assign accept = in_valid_i && !in_stall_o;

  tlv_parse_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .data_byte_i      (data_byte_i),
    .last_in_buffer_i (last_in_buffer_i),
    .result_o         (core_res)
  );

  tlv_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .result_i    (core_res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign byte_kind_o      = out_res.byte_kind;
  assign element_done_o   = out_res.element_done;
  assign element_length_o = out_res.element_length;
  assign numeral_value_o  = out_res.numeral_value;
  assign numeral_ok_o     = out_res.numeral_ok;
  assign buffer_error_o   = out_res.buffer_error;

endmodule

>>> rtl/core/tlv_checker.sv
// Port-level checks of the TLV element parser and their binding.
module tlv_checker import tlv_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  byte_kind_o,
  input logic        element_done_o,
  input logic [15:0] element_length_o,
  input logic [63:0] numeral_value_o,
  input logic        numeral_ok_o,
  input logic        buffer_error_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Numeral flag only on a completed element
  a_ok_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && numeral_ok_o |-> element_done_o)
    else $error("numeral_ok without element_done");

  // Error and completion exclude each other
  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && buffer_error_o |-> !element_done_o)
    else $error("buffer_error on a completed element");

  // Report fields are zero unless an element completes
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !element_done_o |-> element_length_o == 16'd0 &&
    numeral_value_o == 64'd0)
    else $error("report fields set without element_done");

  // Only a length or value byte can complete an element
  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && element_done_o |->
    byte_kind_o == KIND_LENGTH || byte_kind_o == KIND_VALUE)
    else $error("element completed on a type byte");

endmodule

bind tlv_element_parser tlv_checker u_tlv_checker (.*);
